// ----- sv/periodic_template_noise_suppressor_top_macros.svh -----
// Assertion macros shared by the noise suppressor RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef PERIODIC_TEMPLATE_NOISE_SUPPRESSOR_TOP_MACROS_SVH
`define PERIODIC_TEMPLATE_NOISE_SUPPRESSOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PTNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define PTNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ptns_pkg.sv -----
// Package for the periodic template noise suppressor.
// Holds payload types, register codes, controller states and command structs.
package ptns_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int FACTOR_W   = 16;
  localparam int LIMIT_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PQ_W       = 2 * SAMPLE_W + FACTOR_W;  // noise and signal power
  localparam int FRAC_W     = 30;                       // Q0.30 ratio
  localparam int DIV_STEPS  = FRAC_W;
  localparam int SQRT_STEPS = FRAC_W / 2;
  localparam int STEP_W     = 5;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_DENOISE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOISE_SCALE = 2'd0,
    REG_GAIN_FLOOR  = 2'd1,
    REG_NOISE_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                       cmd;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       floored;
    logic                       passed_through;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_READ, ST_SQUARE, ST_POWER, ST_CMP,
    ST_DIV, ST_SQRT_INIT, ST_SQRT, ST_SCALE, ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic accept;
    logic mod_step;
    logic rd;
    logic square;
    logic power;
    logic cmp;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic scale;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
    logic p_gt_q;
    logic q_zero;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- sv/ptns_ram.sv -----
// Generic simple dual-port RAM with registered read.
// No dependencies.
module ptns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- sv/ptns_ctrl.sv -----
// Controller state machine of the noise suppressor.
// Uses ptns_pkg and the assertion macro header.
`include "periodic_template_noise_suppressor_top_macros.svh"

module ptns_ctrl #(
  parameter int MOD_STEPS = 12
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  input  ptns_pkg::dp_sts_t sts,
  output ptns_pkg::ctl_cmd_t cmd
);
  import ptns_pkg::*;

  ctl_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              acc;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc && in_cmd == CMD_DENOISE) begin
          state_nxt = sts.empty ? ST_DONE : ST_MOD;
        end
      end
      ST_MOD: begin
        if (cnt_r == STEP_W'(MOD_STEPS - 1)) state_nxt = ST_READ;
      end
      ST_READ:   state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_POWER;
      ST_POWER:  state_nxt = ST_CMP;
      ST_CMP:    state_nxt = (sts.p_gt_q && !sts.q_zero) ? ST_DIV : ST_SCALE;
      ST_DIV: begin
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) state_nxt = ST_SQRT_INIT;
      end
      ST_SQRT_INIT: state_nxt = ST_SQRT;
      ST_SQRT: begin
        if (cnt_r == STEP_W'(SQRT_STEPS - 1)) state_nxt = ST_SCALE;
      end
      ST_SCALE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // counter runs in the iterative states, clears on every state change
  always_comb begin
    cnt_nxt = '0;
    if (state_nxt == state_r &&
        (state_r == ST_MOD || state_r == ST_DIV || state_r == ST_SQRT)) begin
      cnt_nxt = cnt_r + STEP_W'(1);
    end
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE:      cmd.accept    = acc;
      ST_MOD:       cmd.mod_step  = 1'b1;
      ST_READ:      cmd.rd        = 1'b1;
      ST_SQUARE:    cmd.square    = 1'b1;
      ST_POWER:     cmd.power     = 1'b1;
      ST_CMP:       cmd.cmp       = 1'b1;
      ST_DIV:       cmd.div_step  = 1'b1;
      ST_SQRT_INIT: cmd.sqrt_init = 1'b1;
      ST_SQRT:      cmd.sqrt_step = 1'b1;
      ST_SCALE:     cmd.scale     = 1'b1;
      ST_DONE:      cmd.out_load  = sts.out_free;
      default:      cmd = '0;
    endcase
  end

  `PTNS_ASSERT_NOW(a_load_in_done, cmd.out_load, state_r == ST_DONE && sts.out_free, "result loaded outside done")
  `PTNS_ASSERT_NEXT(a_denoise_starts, acc && in_cmd == CMD_DENOISE, state_r == ST_MOD || state_r == ST_DONE, "denoise transaction did not start")
  `PTNS_ASSERT_NOW(a_div_bound, state_r == ST_DIV, cnt_r < STEP_W'(DIV_STEPS), "divide step counter overrun")
  `PTNS_ASSERT_NEXT(a_load_stays_idle, acc && in_cmd == CMD_LOAD, state_r == ST_IDLE, "load transaction left idle")
endmodule

// ----- sv/ptns_dp.sv -----
// Datapath of the noise suppressor: config registers, template store, phase,
// powers, serial divider and square root, output scaling and result register.
// Uses ptns_pkg and ptns_ram.
module ptns_dp #(
  parameter int NOISE_DEPTH = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ptns_pkg::in_item_t                 in_data,
  input  ptns_pkg::ctl_cmd_t                 cmd,
  output ptns_pkg::dp_sts_t                  sts,
  input  logic                               cfg_valid,
  input  logic [ptns_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptns_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ptns_pkg::out_item_t                out_data
);
  import ptns_pkg::*;

  localparam int AW  = $clog2(NOISE_DEPTH);
  localparam int CW  = $clog2(NOISE_DEPTH + 1);
  localparam int PRW = SAMPLE_W + GAIN_W + 2;
  localparam logic signed [PRW-1:0] SMAX = PRW'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [PRW-1:0] SMIN = -SMAX - PRW'(1);

  // configuration
  logic [FACTOR_W-1:0] factor_r;
  logic [GAIN_W-1:0]   floor_r;
  logic [LIMIT_W-1:0]  limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_W'(8192);
      floor_r  <= GAIN_W'(3277);
      limit_r  <= LIMIT_W'(4096);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NOISE_SCALE: factor_r <= cfg_data;
        REG_GAIN_FLOOR:  floor_r  <= cfg_data;
        REG_NOISE_LIMIT: limit_r  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // template fill and write
  logic [CW-1:0]       count_r, base;
  logic [31:0]         lim;
  logic                store_we;
  logic [SAMPLE_W-1:0] rdata;

  assign lim      = (32'(limit_r) < 32'(NOISE_DEPTH)) ? 32'(limit_r) : 32'(NOISE_DEPTH);
  assign base     = in_data.first ? '0 : count_r;
  assign store_we = cmd.accept && in_data.cmd == CMD_LOAD && 32'(base) < lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.accept && in_data.cmd == CMD_LOAD) begin
      count_r <= store_we ? base + CW'(1) : base;
    end
  end

  // phase reduction by restoring division
  logic [CW-1:0] rem_r, idx_inc;
  logic [AW-1:0] dv_r, phase_r;
  logic [CW:0]   mt;

  assign mt      = {rem_r, dv_r[AW-1]};
  assign idx_inc = rem_r + CW'(1);

  ptns_ram #(.WIDTH(SAMPLE_W), .DEPTH(NOISE_DEPTH)) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (base[AW-1:0]),
    .wdata (in_data.sample),
    .re    (cmd.rd),
    .raddr (rem_r[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.accept && in_data.cmd == CMD_DENOISE && in_data.first) begin
      phase_r <= '0;
    end else if (cmd.rd) begin
      phase_r <= (idx_inc == count_r) ? '0 : idx_inc[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem_r <= '0;
      dv_r  <= in_data.first ? '0 : phase_r;
    end else if (cmd.mod_step) begin
      dv_r  <= dv_r << 1;
      rem_r <= (mt >= {1'b0, count_r}) ? CW'(mt - {1'b0, count_r}) : mt[CW-1:0];
    end
  end

  // sample latch and powers
  logic signed [SAMPLE_W-1:0] s_r;
  logic                       pass_r;
  logic [SAMPLE_W-1:0]        sa, na;
  logic [2*SAMPLE_W-1:0]      sa2_r, na2_r;
  logic [PQ_W-1:0]            p_r, q_r;

  assign sa = s_r[SAMPLE_W-1] ? SAMPLE_W'(-s_r) : s_r;
  assign na = rdata[SAMPLE_W-1] ? SAMPLE_W'(-rdata) : rdata;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r    <= in_data.sample;
      pass_r <= (count_r == '0);
    end
    if (cmd.square) begin
      sa2_r <= sa * sa;
      na2_r <= na * na;
    end
    if (cmd.power) begin
      p_r <= PQ_W'({sa2_r, 12'd0});
      q_r <= PQ_W'(na2_r) * PQ_W'(factor_r);
    end
  end

  // branch choice, serial divide, serial square root
  logic              fl_r, use_sqrt_r;
  logic [GAIN_W-1:0] g_r;
  logic [PQ_W-1:0]   num_r;
  logic [PQ_W:0]     dt;
  logic [FRAC_W-1:0] quo_r, sx_r, sres_r, sbit_r;
  logic [FRAC_W:0]   ssum;

  assign dt   = {num_r, 1'b0};
  assign ssum = {1'b0, sres_r} + {1'b0, sbit_r};

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      fl_r       <= !(p_r > q_r);
      g_r        <= (p_r > q_r) ? GAIN_W'(32768) : floor_r;
      use_sqrt_r <= (p_r > q_r) && (q_r != '0);
      num_r      <= p_r - q_r;
      quo_r      <= '0;
    end
    if (cmd.div_step) begin
      if (dt >= {1'b0, p_r}) begin
        num_r <= PQ_W'(dt - {1'b0, p_r});
        quo_r <= {quo_r[FRAC_W-2:0], 1'b1};
      end else begin
        num_r <= dt[PQ_W-1:0];
        quo_r <= {quo_r[FRAC_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_init) begin
      sx_r   <= quo_r;
      sres_r <= '0;
      sbit_r <= FRAC_W'(1) << (FRAC_W - 2);
    end
    if (cmd.sqrt_step) begin
      if ({1'b0, sx_r} >= ssum) begin
        sx_r   <= FRAC_W'({1'b0, sx_r} - ssum);
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
  end

  // scaling with round half up, then saturation
  logic [GAIN_W-1:0]        gain;
  logic signed [PRW-1:0]    prod_r, y;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign gain = use_sqrt_r ? sres_r[GAIN_W-1:0] : g_r;
  assign y    = prod_r >>> 15;

  always_comb begin
    if (y > SMAX)      y_sat = SMAX[SAMPLE_W-1:0];
    else if (y < SMIN) y_sat = SMIN[SAMPLE_W-1:0];
    else               y_sat = y[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod_r <= PRW'(s_r) * $signed({2'b00, gain}) + PRW'(16384);
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (pass_r) begin
        out_data <= '{sample_out: s_r, floored: 1'b0, passed_through: 1'b1};
      end else begin
        out_data <= '{sample_out: y_sat, floored: fl_r, passed_through: 1'b0};
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.empty    = (count_r == '0);
  assign sts.p_gt_q   = (p_r > q_r);
  assign sts.q_zero   = (q_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;
endmodule

// ----- sv/periodic_template_noise_suppressor_top.sv -----
// Top level of the periodic template noise suppressor.
// Uses ptns_pkg, ptns_ctrl, ptns_dp (which holds ptns_ram).
//
// Channels: in_* carries a transaction {cmd, first, sample}; cmd load appends a
// noise sample to the template (first restarts it), cmd denoise scales an audio
// sample by a spectral subtraction gain and yields one out_* transaction.
// cfg_* writes the noise power scale (0), the gain floor (1) and the template
// limit (2); always ready.
// Load transactions leave the controller idle and give no result.
// Denoise path, accept to out_valid: with an empty template the controller goes
// straight to the done state; otherwise it runs the phase modulo divider (one bit a
// cycle) and, when signal power exceeds a nonzero noise power, the 30-step fraction
// divider and the 15-step square root. Only one transaction is in flight; in_ready
// rises in the same cycle as out_valid.
// Reset (synchronous, rst_n low) empties the template, zeroes the phase and
// restores the register defaults; the store contents are left as they are.
// A stalled receiver holds the result in the output register; a following
// result waits in the done state until that register is free.
module periodic_template_noise_suppressor_top #(
  parameter int NOISE_DEPTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ptns_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ptns_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptns_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptns_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ptns_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  ptns_ctrl #(.MOD_STEPS($clog2(NOISE_DEPTH))) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptns_dp #(.NOISE_DEPTH(NOISE_DEPTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

// ----- verif/tb_periodic_template_noise_suppressor_top.sv -----
// Testbench for the periodic template noise suppressor top level.
// Depends on ptns_pkg and the RTL; a behavioral gain predictor checks each result.
`timescale 1ns / 1ps

module tb_periodic_template_noise_suppressor_top;
  import ptns_pkg::*;

  localparam int DEPTH = 4096;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_acc_q;

  periodic_template_noise_suppressor_top #(.NOISE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic [15:0] factor_q;
  logic [15:0] floor_q;
  logic [12:0] limit_q;
  logic signed [15:0] template_mem [DEPTH];
  int unsigned tmpl_count;
  int unsigned tmpl_phase;

  in_item_t pending_items[$];
  out_item_t expected_samples[$];
  int errors;
  int send_idle_pct;
  int recv_stall_pct;
  int n_checked;
  int n_floored;
  int n_passed;
  bit stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Timeout at %0t", $time);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Spectral subtraction gain model; updates template state
  function automatic void predict_denoise(input in_item_t it);
    out_item_t r;
    int unsigned lim;
    int unsigned idx;
    longint s;
    longint n;
    longint prod;
    longint y;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] g;
    if (it.cmd == CMD_LOAD) begin
      lim = (limit_q < DEPTH) ? limit_q : DEPTH;
      if (it.first) tmpl_count = 0;
      if (tmpl_count < lim) begin
        template_mem[tmpl_count] = it.sample;
        tmpl_count++;
      end
      return;
    end
    if (it.first) tmpl_phase = 0;
    r.floored = 1'b0;
    r.passed_through = 1'b0;
    if (tmpl_count == 0) begin
      r.sample_out = it.sample;
      r.passed_through = 1'b1;
      expected_samples.insert(expected_samples.size(), r);
      return;
    end
    idx = tmpl_phase % tmpl_count;
    tmpl_phase = (idx + 1 == tmpl_count) ? 0 : idx + 1;
    s = it.sample;
    n = template_mem[idx];
    p = (s * s) << 12;
    q = (n * n) * longint'(factor_q);
    if (p > q) begin
      if (q == 0) begin
        g = 32768;
      end else begin
        num = p - q;
        quo = 0;
        for (int i = 0; i < 30; i++) begin
          num = num << 1;
          quo = quo << 1;
          if (num >= p) begin
            num = num - p;
            quo = quo | 1;
          end
        end
        g = isqrt(quo);
      end
    end else begin
      g = floor_q;
      r.floored = 1'b1;
    end
    prod = s * longint'(g) + 16384;
    y = prod >>> 15;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    r.sample_out = y[15:0];
    expected_samples.insert(expected_samples.size(), r);
  endfunction

  // Driver: one transaction at a time from the pending queue
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_acc_q) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && pending_items.size() != 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_data <= pending_items.pop_front();
      in_valid <= 1'b1;
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    in_acc_q <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) predict_denoise(in_data);
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          out_item_t e;
          e = expected_samples.pop_front();
          n_checked++;
          if (e.floored) n_floored++;
          if (e.passed_through) n_passed++;
          if (out_data.sample_out !== e.sample_out)
            begin
              $display("%0t: sample_out exp %0d got %0d", $time, e.sample_out,
                       out_data.sample_out);
              errors++;
            end
          if (out_data.floored !== e.floored) begin
            $display("%0t: floored exp %b got %b", $time, e.floored, out_data.floored);
            errors++;
          end
          if (out_data.passed_through !== e.passed_through) begin
            $display("%0t: passed_through exp %b got %b", $time, e.passed_through,
                     out_data.passed_through);
            errors++;
          end
        end
      end
    end
  end

  task automatic push_item(input logic cmd, input logic first, input logic [15:0] smp);
    in_item_t it;
    it.cmd = cmd;
    it.first = first;
    it.sample = smp;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Wait for everything to drain, then a settle gap for trailing loads
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_NOISE_SCALE: factor_q = val;
      REG_GAIN_FLOOR: floor_q = val;
      default: limit_q = val[12:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Burst: template load then a run of mostly denoise samples, with random items mixed in
  task automatic random_burst(input int n_items);
    int tlen;
    int amp;
    tlen = $urandom_range(1, 24);
    amp = 1 << $urandom_range(4, 15);
    push_item(CMD_LOAD, 1'b1, 16'($signed($urandom_range(0, 2 * amp - 1) - amp)));
    for (int i = 1; i < tlen; i++)
      push_item(CMD_LOAD, 1'b0, 16'($signed($urandom_range(0, 2 * amp - 1) - amp)));
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9) == 0)
        push_item(1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom));
      else
        push_item(CMD_DENOISE, i == 0 || $urandom_range(15) == 0, 16'($urandom));
    end
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_NOISE_SCALE;
    cfg_data = '0;
    errors = 0;
    n_checked = 0;
    n_floored = 0;
    n_passed = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    factor_q = 16'd8192;
    floor_q = 16'd3277;
    limit_q = 13'd4096;
    tmpl_count = 0;
    tmpl_phase = 0;
    phase_idle = '{0, 79, 0, 34};
    phase_stall = '{0, 0, 79, 34};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty template passthrough, extremes, silent sample
    push_item(CMD_DENOISE, 1'b1, 16'h8000);
    push_item(CMD_DENOISE, 1'b0, 16'h7FFF);
    push_item(CMD_LOAD, 1'b1, 16'h0000);
    push_item(CMD_LOAD, 1'b0, 16'h8000);
    push_item(CMD_LOAD, 1'b0, 16'h7FFF);
    push_item(CMD_LOAD, 1'b0, 16'h0100);
    push_item(CMD_DENOISE, 1'b1, 16'h7FFF);
    push_item(CMD_DENOISE, 1'b0, 16'h8000);
    push_item(CMD_DENOISE, 1'b0, 16'h0000);
    push_item(CMD_DENOISE, 1'b0, 16'h8000);
    push_item(CMD_DENOISE, 1'b0, 16'h4000);
    drain();
    // Floor above one with a zero noise scale; phase beyond a shortened template wraps
    write_reg(REG_GAIN_FLOOR, 16'hFFFF);
    write_reg(REG_NOISE_SCALE, 16'd0);
    push_item(CMD_DENOISE, 1'b0, 16'h0000);
    push_item(CMD_LOAD, 1'b1, 16'h1234);
    push_item(CMD_DENOISE, 1'b0, 16'h7FFF);
    push_item(CMD_DENOISE, 1'b0, 16'h8000);
    drain();
    // Template full at a limit of one, then an empty template via limit zero
    write_reg(REG_NOISE_SCALE, 16'hFFFF);
    write_reg(REG_NOISE_LIMIT, 16'd1);
    push_item(CMD_LOAD, 1'b1, 16'h0400);
    push_item(CMD_LOAD, 1'b0, 16'h7000);
    push_item(CMD_DENOISE, 1'b1, 16'h7FFF);
    push_item(CMD_DENOISE, 1'b0, 16'h0401);
    drain();
    write_reg(REG_NOISE_LIMIT, 16'd0);
    push_item(CMD_LOAD, 1'b1, 16'h0400);
    push_item(CMD_DENOISE, 1'b1, 16'h5555);
    drain();

    // Random phases with distinct settings and traffic shaping
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_NOISE_SCALE, 16'd8192);
          write_reg(REG_GAIN_FLOOR, 16'd3277);
          write_reg(REG_NOISE_LIMIT, 16'd4096);
        end
        1: begin
          write_reg(REG_NOISE_SCALE, 16'($urandom_range(0, 65535)));
          write_reg(REG_GAIN_FLOOR, 16'd32768);
          write_reg(REG_NOISE_LIMIT, 16'd8);
        end
        2: begin
          write_reg(REG_NOISE_SCALE, 16'd4096);
          write_reg(REG_GAIN_FLOOR, 16'd0);
          write_reg(REG_NOISE_LIMIT, 16'($urandom_range(1, 4096)));
        end
        default: begin
          write_reg(REG_NOISE_SCALE, 16'd1);
          write_reg(REG_GAIN_FLOOR, 16'($urandom_range(0, 65535)));
          write_reg(REG_NOISE_LIMIT, 16'd8191);
        end
      endcase
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int b = 0; b < 6; b++) random_burst($urandom_range(10, 30));
      drain();
    end

    // Template loaded past a mid-size limit, then denoised from phase zero
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_NOISE_LIMIT, 16'd96);
    push_item(CMD_LOAD, 1'b1, 16'($urandom));
    for (int i = 0; i < 100; i++) push_item(CMD_LOAD, 1'b0, 16'($urandom));
    for (int i = 0; i < 20; i++) push_item(CMD_DENOISE, i == 0, 16'($urandom));
    drain();

    $display("Checked %0d results: %0d floored, %0d passed through, 4 traffic phases",
             n_checked, n_floored, n_passed);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
